// ===== design/rpn_stack_calculator_defines.svh =====
// Assertion macros used by the top-level RTL.
`ifndef RPN_STACK_CALCULATOR_DEFINES_SVH
`define RPN_STACK_CALCULATOR_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define RPN_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rpn assertion failed");

`define RPN_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rpn assertion failed");

`else

`define RPN_ASSERT_IMPL(label, clk, rst, ante, cons)

`define RPN_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== design/rpn_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package rpn_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int DATA_W      = 32;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int CMD_W       = 3;
  localparam int COUNT_W     = 5;
  localparam int STATUS_W    = 2;
  localparam int STEP_W      = $clog2(DATA_W);
  localparam int IN_W        = 40;
  localparam int OUT_W       = 40;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH = 3'd0,
    CMD_ADD  = 3'd1,
    CMD_SUB  = 3'd2,
    CMD_MUL  = 3'd3,
    CMD_DIV  = 3'd4,
    CMD_DROP = 3'd5,
    CMD_SWAP = 3'd6
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK   = 2'd0,
    ST_FEW  = 2'd1,
    ST_DIVZ = 2'd2,
    ST_FULL = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD_SEC,
    S_GOT_SEC,
    S_SWAP_WR,
    S_EXEC,
    S_TOP_RD,
    S_TOP_GOT
  } state_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [DATA_W-1:0] wdata;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic              start;
    cmd_t              op;
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [DATA_W-1:0] result;
  } alu_rsp_t;

  typedef struct packed {
    logic             idle;
    logic [CNT_W-1:0] count;
  } ctrl_stat_t;

endpackage

`default_nettype wire

// ===== design/rpn_stack_mem.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rpn_stack_mem
  import rpn_pkg::*;
(
  input  wire logic              clk,
  input  wire mem_req_t          req,
  output logic      [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [STACK_DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end

endmodule

`default_nettype wire

// ===== design/rpn_alu.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rpn_alu
  import rpn_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire alu_req_t req,
  output alu_rsp_t      rsp
);

  logic              busy;
  logic              done;
  cmd_t              op;
  logic              neg;
  logic [STEP_W-1:0] step;
  logic [DATA_W-1:0] acc;
  logic [DATA_W-1:0] opx;
  logic [DATA_W-1:0] opy;

  logic [DATA_W:0]   rem_sh;
  logic [DATA_W:0]   diff;
  logic [DATA_W-1:0] a_mag;
  logic [DATA_W-1:0] b_mag;

  // restoring divide step: acc holds remainder, opx shifts dividend out / quotient in
  always_comb begin
    rem_sh = {acc, opx[DATA_W-1]};
    diff   = rem_sh - {1'b0, opy};
    a_mag  = req.a[DATA_W-1] ? (~req.a + DATA_W'(1)) : req.a;
    b_mag  = req.b[DATA_W-1] ? (~req.b + DATA_W'(1)) : req.b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        case (req.op)
          CMD_MUL, CMD_DIV: busy <= 1'b1;
          default:          done <= 1'b1;
        endcase
      end else if (busy && step == STEP_W'(DATA_W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      op   <= req.op;
      step <= '0;
      neg  <= req.a[DATA_W-1] ^ req.b[DATA_W-1];
      case (req.op)
        CMD_ADD: acc <= req.a + req.b;
        CMD_SUB: acc <= req.a - req.b;
        CMD_MUL: begin
          acc <= '0;
          opx <= req.a;
          opy <= req.b;
        end
        CMD_DIV: begin
          acc <= '0;
          opx <= a_mag;
          opy <= b_mag;
        end
        default: acc <= '0;
      endcase
    end else if (busy) begin
      step <= step + STEP_W'(1);
      if (op == CMD_MUL) begin
        acc <= acc + (opy[0] ? opx : '0);
        opx <= {opx[DATA_W-2:0], 1'b0};
        opy <= {1'b0, opy[DATA_W-1:1]};
      end else if (!diff[DATA_W]) begin
        acc <= diff[DATA_W-1:0];
        opx <= {opx[DATA_W-2:0], 1'b1};
      end else begin
        acc <= rem_sh[DATA_W-1:0];
        opx <= {opx[DATA_W-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    rsp.busy   = busy;
    rsp.done   = done;
    rsp.result = acc;
    if (op == CMD_DIV) begin
      rsp.result = neg ? (~opx + DATA_W'(1)) : opx;
    end
  end

endmodule

`default_nettype wire

// ===== design/rpn_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rpn_ctrl
  import rpn_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  input  wire logic [IN_W-1:0]   s_tdata,
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  output logic      [OUT_W-1:0]  m_tdata,
  output mem_req_t               mem_req,
  input  wire logic [DATA_W-1:0] mem_rdata,
  output alu_req_t               alu_req,
  input  wire alu_rsp_t          alu_rsp,
  output ctrl_stat_t             stat
);

  state_t            state, state_next;
  logic [CNT_W-1:0]  count, count_next;
  cmd_t              cmd, cmd_next;
  status_t           status, status_next;
  logic [DATA_W-1:0] op_top, op_top_next;
  logic              out_load;

  cmd_t              in_cmd;
  logic [DATA_W-1:0] in_value;
  logic [ADDR_W-1:0] cnt_m1;
  logic [ADDR_W-1:0] cnt_m2;
  logic [DATA_W-1:0] top_value;
  logic [CNT_W-1:0]  cnt_dec1;
  logic [CNT_W-1:0]  cnt_dec2;

  always_comb begin
    in_cmd    = cmd_t'(s_tdata[CMD_W-1:0]);
    in_value  = s_tdata[CMD_W +: DATA_W];
    cnt_dec1  = count - CNT_W'(1);
    cnt_dec2  = count - CNT_W'(2);
    cnt_m1    = cnt_dec1[ADDR_W-1:0];
    cnt_m2    = cnt_dec2[ADDR_W-1:0];
    top_value = (count == '0) ? '0 : mem_rdata;
    s_tready  = (state == S_IDLE);
    stat.idle  = (state == S_IDLE);
    stat.count = count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    cmd    <= cmd_next;
    status <= status_next;
    op_top <= op_top_next;
  end

  always_comb begin
    state_next    = state;
    count_next    = count;
    cmd_next      = cmd;
    status_next   = status;
    op_top_next   = op_top;
    out_load      = 1'b0;
    mem_req.we    = 1'b0;
    mem_req.waddr = count[ADDR_W-1:0];
    mem_req.wdata = in_value;
    mem_req.raddr = (state == S_RD_SEC) ? cnt_m2 : cnt_m1;
    alu_req.start = 1'b0;
    alu_req.op    = cmd;
    alu_req.a     = mem_rdata;
    alu_req.b     = op_top;

    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd_next    = in_cmd;
          status_next = ST_OK;
          state_next  = S_TOP_RD;
          case (in_cmd)
            CMD_PUSH: begin
              if (count == CNT_W'(STACK_DEPTH)) begin
                status_next = ST_FULL;
              end else begin
                mem_req.we = 1'b1;
                count_next = count + CNT_W'(1);
              end
            end
            CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV, CMD_SWAP: begin
              if (count < CNT_W'(2)) begin
                status_next = ST_FEW;
              end else begin
                state_next = S_RD_SEC;
              end
            end
            CMD_DROP: begin
              if (count == '0) begin
                status_next = ST_FEW;
              end else begin
                count_next = cnt_dec1;
              end
            end
            default: ;
          endcase
        end
      end
      S_RD_SEC: begin
        op_top_next = mem_rdata;
        state_next  = S_GOT_SEC;
      end
      S_GOT_SEC: begin
        if (cmd == CMD_SWAP) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = cnt_m1;
          mem_req.wdata = mem_rdata;
          state_next    = S_SWAP_WR;
        end else if (cmd == CMD_DIV && op_top == '0) begin
          status_next = ST_DIVZ;
          state_next  = S_TOP_RD;
        end else begin
          alu_req.start = 1'b1;
          state_next    = S_EXEC;
        end
      end
      S_SWAP_WR: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = cnt_m2;
        mem_req.wdata = op_top;
        state_next    = S_TOP_RD;
      end
      S_EXEC: begin
        if (alu_rsp.done) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = cnt_m2;
          mem_req.wdata = alu_rsp.result;
          count_next    = cnt_dec1;
          state_next    = S_TOP_RD;
        end
      end
      S_TOP_RD: begin
        state_next = S_TOP_GOT;
      end
      S_TOP_GOT: begin
        if (!m_tvalid || m_tready) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= OUT_W'({status, COUNT_W'(count), top_value});
    end
  end

endmodule

`default_nettype wire

// ===== design/rpn_stack_calculator.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "rpn_stack_calculator_defines.svh"

// Reverse Polish integer calculator on a 16-entry stack of signed 32-bit values.
// One command item in, one result item out. Every command ends by reading the new
// top entry through the stack memory's single read port; add, sub, mul, div and
// swap first read the top two entries and write back, bar a divide by zero. Mul and
// div run on the shared shift-add / restoring-divide unit, one bit per cycle over 32 bits.
// A finished result sits in the output register while the next item is taken.
module rpn_stack_calculator
  import rpn_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_tvalid,
  output logic                  s_tready,
  input  wire logic [IN_W-1:0]  s_tdata,  // cmd[2:0], value[34:3], zero pad
  output logic                  m_tvalid,
  input  wire logic             m_tready,
  output logic      [OUT_W-1:0] m_tdata   // top_value[31:0], stack_count[36:32],
                                          // status[38:37], zero pad
);

  mem_req_t          mem_req;
  logic [DATA_W-1:0] mem_rdata;
  alu_req_t          alu_req;
  alu_rsp_t          alu_rsp;
  ctrl_stat_t        stat;

  rpn_stack_mem u_mem (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

  rpn_alu u_alu (
    .clk (clk),
    .rst (rst),
    .req (alu_req),
    .rsp (alu_rsp)
  );

  rpn_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata),
    .alu_req   (alu_req),
    .alu_rsp   (alu_rsp),
    .stat      (stat)
  );

  `RPN_ASSERT_NEXT(a_one_at_a_time, clk, rst, s_tvalid && s_tready, !s_tready)
  `RPN_ASSERT_IMPL(a_alu_free, clk, rst, alu_req.start, !alu_rsp.busy && stat.count >= CNT_W'(2))
  `RPN_ASSERT_IMPL(a_count_bound, clk, rst, 1'b1, stat.count <= CNT_W'(STACK_DEPTH))
  `RPN_ASSERT_IMPL(a_write_in_range, clk, rst, mem_req.we, stat.count != CNT_W'(STACK_DEPTH) || !stat.idle)

endmodule

`default_nettype wire

// ===== sim/rpn_result_checker.sv =====
`timescale 1ns / 1ps

module rpn_result_checker
  import rpn_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_tvalid,
  input  wire logic             s_tready,
  input  wire logic [IN_W-1:0]  s_tdata,  // cmd[2:0], value[34:3], zero pad
  input  wire logic             m_tvalid,
  input  wire logic             m_tready,
  input  wire logic [OUT_W-1:0] m_tdata,  // top_value[31:0], stack_count[36:32],
                                          // status[38:37], zero pad
  output int                    errors,
  output int                    outstanding
);

  localparam int VALUE_LSB  = CMD_W;
  localparam int COUNT_LSB  = DATA_W;
  localparam int STATUS_LSB = DATA_W + COUNT_W;

  typedef struct packed {
    logic [DATA_W-1:0]  top;
    logic [COUNT_W-1:0] count;
    status_t            status;
  } calc_result_t;

  calc_result_t      expected_results[$];
  logic [DATA_W-1:0] stack_mem [STACK_DEPTH];
  int                entries;

  task automatic apply_command(input logic [CMD_W-1:0] cmd, input logic [DATA_W-1:0] value);
    logic [DATA_W-1:0] top_v;
    logic [DATA_W-1:0] sec_v;
    logic [DATA_W-1:0] res;
    longint            quo;
    status_t           st;
    calc_result_t      r;
    st = ST_OK;
    case (cmd)
      CMD_PUSH: begin
        if (entries >= STACK_DEPTH) begin
          st = ST_FULL;
        end else begin
          stack_mem[entries] = value;
          entries++;
        end
      end
      CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV: begin
        if (entries < 2) begin
          st = ST_FEW;
        end else begin
          top_v = stack_mem[entries-1];
          sec_v = stack_mem[entries-2];
          if (cmd == CMD_DIV && top_v == '0) begin
            st = ST_DIVZ;
          end else begin
            case (cmd)
              CMD_ADD: res = sec_v + top_v;
              CMD_SUB: res = sec_v - top_v;
              CMD_MUL: res = sec_v * top_v;
              default: begin
                // 64-bit quotient so most-negative over minus one wraps cleanly
                quo = longint'($signed(sec_v)) / longint'($signed(top_v));
                res = DATA_W'(quo);
              end
            endcase
            stack_mem[entries-2] = res;
            entries--;
          end
        end
      end
      CMD_DROP: begin
        if (entries == 0) st = ST_FEW;
        else entries--;
      end
      CMD_SWAP: begin
        if (entries < 2) begin
          st = ST_FEW;
        end else begin
          top_v = stack_mem[entries-1];
          stack_mem[entries-1] = stack_mem[entries-2];
          stack_mem[entries-2] = top_v;
        end
      end
      default: ;
    endcase
    r.top    = (entries > 0) ? stack_mem[entries-1] : '0;
    r.count  = COUNT_W'(entries);
    r.status = st;
    expected_results.push_back(r);
  endtask

  always @(posedge clk) begin : watch
    calc_result_t want;
    if (rst) begin
      entries = 0;
      errors  = 0;
      expected_results.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_results.size() == 0) begin
          $error("result item with no command outstanding: tdata %h", m_tdata);
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (m_tdata[COUNT_LSB-1:0] !== want.top) begin
            $error("top_value: expected %0d, got %0d", $signed(want.top),
                   $signed(m_tdata[COUNT_LSB-1:0]));
            errors++;
          end
          if (m_tdata[STATUS_LSB-1:COUNT_LSB] !== want.count) begin
            $error("stack_count: expected %0d, got %0d", want.count,
                   m_tdata[STATUS_LSB-1:COUNT_LSB]);
            errors++;
          end
          if (m_tdata[STATUS_LSB+STATUS_W-1:STATUS_LSB] !== want.status) begin
            $error("status: expected %0d, got %0d", want.status,
                   m_tdata[STATUS_LSB+STATUS_W-1:STATUS_LSB]);
            errors++;
          end
        end
      end
      if (s_tvalid && s_tready)
        apply_command(s_tdata[CMD_W-1:0], s_tdata[VALUE_LSB+DATA_W-1:VALUE_LSB]);
    end
    outstanding = expected_results.size();
  end

endmodule

// ===== sim/tb_rpn_stack_calculator.sv =====
`timescale 1ns / 1ps

module tb_rpn_stack_calculator;
  import rpn_pkg::*;

  localparam logic [CMD_W-1:0]  CMD_UNUSED = 3'd7;
  localparam logic [DATA_W-1:0] INT_MIN    = 32'h8000_0000;
  localparam logic [DATA_W-1:0] INT_MAX    = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] MINUS_ONE  = 32'hFFFF_FFFF;

  logic             clk      = 1'b0;
  logic             rst      = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [IN_W-1:0]  s_tdata  = '0;  // cmd[2:0], value[34:3], zero pad
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;        // top_value[31:0], stack_count[36:32],
                                    // status[38:37], zero pad
  int               errors;
  int               outstanding;
  bit               no_gaps = 1'b0;
  int               ready_hold = 0;
  int               push_pct;

  rpn_stack_calculator uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  rpn_result_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .errors      (errors),
    .outstanding (outstanding)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic [DATA_W-1:0] pick_operand();
    case ($urandom_range(0, 9))
      0, 1, 2: return DATA_W'($signed($urandom_range(0, 16)) - 8);
      3: begin
        case ($urandom_range(0, 4))
          0: return '0;
          1: return 32'd1;
          2: return MINUS_ONE;
          3: return INT_MIN;
          default: return INT_MAX;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [CMD_W-1:0] pick_command(int pct);
    if ($urandom_range(0, 99) < pct) return CMD_PUSH;
    if ($urandom_range(0, 29) == 0) return CMD_UNUSED;
    return CMD_W'($urandom_range(1, 6));
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [DATA_W-1:0] value);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tdata  <= IN_W'({value, cmd});
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  always @(negedge clk) begin : ready_drive
    int r;
    if (ready_hold == 0) begin
      r = $urandom_range(0, 99);
      if (r < 50) begin
        m_tready   <= 1'b1;
        ready_hold = $urandom_range(1, 40);
      end else if (r < 55) begin
        m_tready   <= 1'b1;
        ready_hold = $urandom_range(100, 300);
      end else if (r < 85) begin
        m_tready   <= 1'b0;
        ready_hold = $urandom_range(1, 3);
      end else if (r < 95) begin
        m_tready   <= 1'b0;
        ready_hold = $urandom_range(4, 12);
      end else begin
        m_tready   <= 1'b0;
        ready_hold = $urandom_range(20, 60);
      end
    end else begin
      ready_hold--;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_command(CMD_DROP, '0);
    send_command(CMD_ADD, '0);
    send_command(CMD_SWAP, '0);
    send_command(CMD_PUSH, INT_MIN);
    send_command(CMD_DIV, '0);
    send_command(CMD_PUSH, MINUS_ONE);
    send_command(CMD_DIV, '0);          // most negative over minus one
    send_command(CMD_PUSH, '0);
    send_command(CMD_DIV, '0);          // divide by zero keeps operands
    send_command(CMD_DROP, '0);
    send_command(CMD_PUSH, INT_MAX);
    send_command(CMD_ADD, '0);
    send_command(CMD_PUSH, INT_MAX);
    send_command(CMD_MUL, '0);
    send_command(CMD_PUSH, 32'd2);
    send_command(CMD_SWAP, '0);
    send_command(CMD_SUB, '0);
    send_command(CMD_PUSH, -32'sd7);
    send_command(CMD_PUSH, 32'd2);
    send_command(CMD_DIV, '0);          // truncates toward zero
    send_command(CMD_UNUSED, 32'h5555_5555);
    send_command(CMD_PUSH, 32'hAAAA_AAAA);
    send_command(CMD_DROP, '0);
    send_command(CMD_DROP, '0);
    send_command(CMD_DROP, '0);

    // each burst picks a push share of 15, 50 or 85 percent at random, so it fills, drains or churns the stack
    for (int burst = 0; burst < 14; burst++) begin
      case ($urandom_range(0, 2))
        0: push_pct = 15;
        1: push_pct = 50;
        default: push_pct = 85;
      endcase
      no_gaps = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < 50; i++)
        send_command(pick_command(push_pct), pick_operand());
    end
    s_tvalid <= 1'b0;

    while (outstanding != 0) @(negedge clk);
    repeat (60) @(negedge clk);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
